@@ design/sspd_pkg.sv @@
// Shared constants, types and codes for the sync/checksum packet deframer.
`timescale 1ns / 1ps
`default_nettype none
package sspd_pkg;

  localparam int NUM_VALUES = 48;
  localparam int CHECK_POS  = 2 * NUM_VALUES + 2;
  localparam int POS_W      = $clog2(CHECK_POS + 1);
  localparam int IDX_W      = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
  localparam int BYTE_W     = 8;
  localparam int VAL_W      = 16;
  localparam int SLOT_W     = 6;
  localparam int CNT_W      = 16;
  localparam int ALU_W      = 16;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h40;

  localparam logic STAT_GOOD = 1'b0;
  localparam logic STAT_BAD  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_COUNT,
    ST_RD,
    ST_EMIT,
    ST_BAD
  } state_t;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage
`default_nettype wire

@@ design/sspd_ram.sv @@
// Single-port-write, registered-read RAM for the decoded value store.
`timescale 1ns / 1ps
`default_nettype none
module sspd_ram #(
  parameter int DEPTH = 48,
  parameter int WIDTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/sspd_alu.sv @@
// Shared add/subtract unit: checksum accumulate, checksum compare, counter bumps.
`timescale 1ns / 1ps
`default_nettype none
module sspd_alu (
  input  wire sspd_pkg::alu_req_t     req,
  output logic [sspd_pkg::ALU_W-1:0] y
);
  import sspd_pkg::*;

  always_comb begin
    case (req.op)
      ALU_ADD: y = req.a + req.b;
      ALU_SUB: y = req.a - req.b;
      default: y = req.a + req.b;
    endcase
  end

endmodule
`default_nettype wire

@@ design/sync_sum_packet_deframer.sv @@
// Sync-byte packet deframer with 8-bit additive checksum: sequencer, value store, output register.
// Each received byte is taken, then processed through the shared adder, before the next is taken.
// Packet end: compare, then counter bump; a good packet then drains its values, each by a store
//   read and an output load, a bad one gives one result; no byte meanwhile.
// First result: registered via the process, count, store-read and emit states (bad: no store read).
// Reset (rst, synchronous, active high): hunting for sync, sum and counters cleared, output
//   empty; the value store is not cleared (every entry is written before it is read).
`timescale 1ns / 1ps
`default_nettype none
module sync_sum_packet_deframer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [sspd_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic                         rx_valid,
  output logic                              rx_ready,
  output logic [sspd_pkg::VAL_W-1:0]        sample_value,
  output logic [sspd_pkg::SLOT_W-1:0]       sample_slot,
  output logic                              last_of_run,
  output logic                              status,
  output logic [sspd_pkg::CNT_W-1:0]        good_total,
  output logic [sspd_pkg::CNT_W-1:0]        bad_total,
  output logic                              out_valid,
  input  wire logic                         out_ready
);
  import sspd_pkg::*;

  localparam logic [POS_W-1:0] POS_ZERO  = '0;
  localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TWO   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_THREE = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CHECK = POS_W'(CHECK_POS);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_VALUES - 1);

  // Sequencer and datapath state
  state_t              state, state_next;
  logic [BYTE_W-1:0]   byte_q;
  logic [POS_W-1:0]    byte_pos, byte_pos_next;
  logic [BYTE_W-1:0]   running_sum, running_sum_next;
  logic [BYTE_W-1:0]   high_hold, high_hold_next;
  logic [CNT_W-1:0]    good_count, good_count_next;
  logic [CNT_W-1:0]    bad_count, bad_count_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic                chk_ok, chk_ok_next;

  // Shared adder
  alu_req_t            alu_req;
  logic [ALU_W-1:0]    alu_y;

  // Value store
  logic                ram_we, ram_re;
  logic [POS_W-1:0]    wr_off;
  logic [IDX_W-1:0]    ram_waddr;
  logic [VAL_W-1:0]    ram_rdata;

  // Output register load
  logic                out_load;
  logic [VAL_W-1:0]    ld_value;
  logic [SLOT_W-1:0]   ld_slot;
  logic                ld_last;
  logic                ld_status;
  logic                out_free;

  sspd_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  // Value i arrives on odd byte positions 2i+3; offset by three, halve for the slot.
  assign wr_off    = byte_pos - POS_THREE;
  assign ram_waddr = wr_off[IDX_W:1];

  sspd_ram #(
    .DEPTH (NUM_VALUES),
    .WIDTH (VAL_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({high_hold, byte_q}),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Output register is free when empty or when its current result goes this cycle
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= '0;
      running_sum <= '0;
      high_hold   <= '0;
      good_count  <= '0;
      bad_count   <= '0;
      idx         <= '0;
      chk_ok      <= 1'b0;
    end else begin
      byte_pos    <= byte_pos_next;
      running_sum <= running_sum_next;
      high_hold   <= high_hold_next;
      good_count  <= good_count_next;
      bad_count   <= bad_count_next;
      idx         <= idx_next;
      chk_ok      <= chk_ok_next;
    end
  end

  // Incoming byte register: held until the process cycle
  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      byte_q <= rx_byte;
    end
  end

  always_comb begin
    state_next       = state;
    rx_ready         = 1'b0;
    alu_req.op       = ALU_ADD;
    alu_req.a        = '0;
    alu_req.b        = '0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    out_load         = 1'b0;
    ld_value         = '0;
    ld_slot          = '0;
    ld_last          = 1'b0;
    ld_status        = STAT_GOOD;
    byte_pos_next    = byte_pos;
    running_sum_next = running_sum;
    high_hold_next   = high_hold;
    good_count_next  = good_count;
    bad_count_next   = bad_count;
    idx_next         = idx;
    chk_ok_next      = chk_ok;

    case (state)
      ST_IDLE: begin
        rx_ready = 1'b1;
        if (rx_valid) begin
          state_next = ST_PROC;
        end
      end

      ST_PROC: begin
        state_next = ST_IDLE;
        if (byte_pos == POS_ZERO) begin
          // hunting: only the sync byte opens a packet
          if (byte_q == SYNC_BYTE) begin
            running_sum_next = byte_q;
            byte_pos_next    = POS_ONE;
          end
        end else if (byte_pos != POS_CHECK) begin
          alu_req.op       = ALU_ADD;
          alu_req.a        = {{(ALU_W-BYTE_W){1'b0}}, running_sum};
          alu_req.b        = {{(ALU_W-BYTE_W){1'b0}}, byte_q};
          running_sum_next = alu_y[BYTE_W-1:0];
          if (byte_pos >= POS_TWO) begin
            if (!byte_pos[0]) begin
              high_hold_next = byte_q;
            end else begin
              ram_we = 1'b1;
            end
          end
          byte_pos_next = byte_pos + POS_ONE;
        end else begin
          // checksum byte: compare through the shared unit
          alu_req.op    = ALU_SUB;
          alu_req.a     = {{(ALU_W-BYTE_W){1'b0}}, running_sum};
          alu_req.b     = {{(ALU_W-BYTE_W){1'b0}}, byte_q};
          chk_ok_next   = (alu_y[BYTE_W-1:0] == '0);
          byte_pos_next = POS_ZERO;
          state_next    = ST_COUNT;
        end
      end

      ST_COUNT: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = chk_ok ? good_count : bad_count;
        alu_req.b  = ALU_W'(1);
        if (chk_ok) begin
          good_count_next = alu_y;
          idx_next        = '0;
          state_next      = ST_RD;
        end else begin
          bad_count_next = alu_y;
          state_next     = ST_BAD;
        end
      end

      ST_RD: begin
        ram_re     = 1'b1;
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_value  = ram_rdata;
          ld_slot   = SLOT_W'(idx);
          ld_last   = (idx == IDX_LAST);
          ld_status = STAT_GOOD;
          if (idx == IDX_LAST) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = ST_RD;
          end
        end
      end

      ST_BAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_value   = '0;
          ld_slot    = '0;
          ld_last    = 1'b1;
          ld_status  = STAT_BAD;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: one result held until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_value <= ld_value;
      sample_slot  <= ld_slot;
      last_of_run  <= ld_last;
      status       <= ld_status;
      good_total   <= good_count;
      bad_total    <= bad_count;
    end
  end

  // A load never overwrites a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten before transfer");

  // Packet position never runs past the checksum byte
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_pos <= POS_CHECK)
    else $error("byte position beyond checksum byte");

  // A bad-checksum result is a single zero result marking the end of the run
  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_BAD) |->
      (sample_value == '0 && sample_slot == '0 && last_of_run))
    else $error("malformed bad-status result");

  // On a good packet the end marker sits on the final slot only
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_GOOD) |->
      (last_of_run == (sample_slot == SLOT_W'(NUM_VALUES - 1))))
    else $error("end marker on wrong slot");

  // No byte is taken while a packet's results are still being produced
  a_no_take_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD || state == ST_EMIT || state == ST_BAD || state == ST_COUNT)
      |-> !rx_ready)
    else $error("byte taken during result drain");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for sync_sum_packet_deframer: byte stimulus, predictor, scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import sspd_pkg::*;

  // Packet layout: sync, spare byte, 2*NUM_VALUES data bytes, checksum.
  localparam int PKT_LEN        = CHECK_POS + 1;
  localparam int ITEM_TARGET    = 330;
  // Long output hold-off: several drains' worth, so the input side backs up.
  localparam int HOLD_CYCLES    = 300;
  // Longest stretch with no transfer on either side: the hold-off plus slack.
  localparam int WATCHDOG_LIMIT = 2000;
  // Settling time after the last expected sample: latency plus a full drain.
  localparam int TAIL_CYCLES    = 4 * NUM_VALUES;
  localparam int REPORT_MAX     = 10;

  // Hunting-mode noise: bit extremes and near misses of the sync byte.
  localparam logic [BYTE_W-1:0] HUNT_BYTES [11] = '{
    8'h00, 8'hFF, 8'h3F, 8'h41, 8'hC0, 8'h80, 8'h01, 8'h7F, 8'hBF, 8'h55, 8'hAA
  };

  typedef enum logic [1:0] {
    PH_SRC_BUSY,
    PH_DST_BUSY,
    PH_FREE
  } traffic_phase_t;

  // One result transfer, field by field.
  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic              stat;
    logic [CNT_W-1:0]  good;
    logic [CNT_W-1:0]  bad;
  } sample_t;

  // Deframer predictor plus queue of samples still owed by the block.
  class deframe_scoreboard;
    logic [POS_W-1:0]  byte_pos;
    logic [BYTE_W-1:0] running_sum;
    logic [BYTE_W-1:0] high_hold;
    logic [VAL_W-1:0]  value_store [NUM_VALUES];
    logic [CNT_W-1:0]  good_count;
    logic [CNT_W-1:0]  bad_count;
    sample_t           owed_q [$];
    int                mismatches;
    int                samples_seen;

    function new();
      byte_pos     = '0;
      running_sum  = '0;
      high_hold    = '0;
      good_count   = '0;
      bad_count    = '0;
      mismatches   = 0;
      samples_seen = 0;
    endfunction

    // Called for every accepted byte; queues the samples a packet end produces.
    function void note_byte(logic [BYTE_W-1:0] b);
      sample_t s;
      int      i;
      if (byte_pos == 0) begin
        // hunting: anything but sync is dropped
        if (b == SYNC_BYTE) begin
          running_sum = b;
          byte_pos    = POS_W'(1);
        end
      end else if (byte_pos < CHECK_POS) begin
        // sync inside a packet is plain data
        running_sum = running_sum + b;
        if (byte_pos >= 2) begin
          if (!byte_pos[0]) begin
            high_hold = b;
          end else begin
            i = (int'(byte_pos) - 3) >> 1;
            value_store[i] = {high_hold, b};
          end
        end
        byte_pos = byte_pos + 1'b1;
      end else begin
        byte_pos = '0;
        if (running_sum != b) begin
          // checksum failure: one bad-status sample, stored values hidden
          bad_count = bad_count + 1'b1;
          s.value = '0;
          s.slot  = '0;
          s.last  = 1'b1;
          s.stat  = STAT_BAD;
          s.good  = good_count;
          s.bad   = bad_count;
          owed_q.push_back(s);
        end else begin
          good_count = good_count + 1'b1;
          for (i = 0; i < NUM_VALUES; i++) begin
            s.value = value_store[i];
            s.slot  = SLOT_W'(i);
            s.last  = (i == NUM_VALUES - 1);
            s.stat  = STAT_GOOD;
            s.good  = good_count;
            s.bad   = bad_count;
            owed_q.push_back(s);
          end
        end
      end
    endfunction

    // Called for every accepted sample; compares with the oldest owed one.
    function void check_sample(sample_t got);
      sample_t want;
      samples_seen++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] unexpected sample: value=%h slot=%0d last=%b status=%b good=%0d bad=%0d",
                   $realtime, got.value, got.slot, got.last, got.stat, got.good, got.bad);
        return;
      end
      want = owed_q.pop_front();
      if (got.value !== want.value || got.slot !== want.slot || got.last !== want.last ||
          got.stat !== want.stat || got.good !== want.good || got.bad !== want.bad) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("[%0t] sample mismatch", $realtime);
          $display("  expected value=%h slot=%0d last=%b status=%b good=%0d bad=%0d",
                   want.value, want.slot, want.last, want.stat, want.good, want.bad);
          $display("  actual   value=%h slot=%0d last=%b status=%b good=%0d bad=%0d",
                   got.value, got.slot, got.last, got.stat, got.good, got.bad);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst       = 1'b1;
  logic [BYTE_W-1:0]   rx_byte   = '0;
  logic                rx_valid  = 1'b0;
  logic                rx_ready;
  logic [VAL_W-1:0]    sample_value;
  logic [SLOT_W-1:0]   sample_slot;
  logic                last_of_run;
  logic                status;
  logic [CNT_W-1:0]    good_total;
  logic [CNT_W-1:0]    bad_total;
  logic                out_valid;
  logic                out_ready = 1'b0;

  deframe_scoreboard   sb = new();
  traffic_phase_t      phase        = PH_SRC_BUSY;
  int                  src_idle_pct = 36;
  int                  dst_idle_pct = 47;
  int                  bytes_sent   = 0;
  int                  packets_sent = 0;
  int                  stall_cycles = 0;
  bit                  hold_done    = 1'b0;

  sync_sum_packet_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .sample_value (sample_value),
    .sample_slot  (sample_slot),
    .last_of_run  (last_of_run),
    .status       (status),
    .good_total   (good_total),
    .bad_total    (bad_total),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor: sees pre-edge values, so transfers are judged exactly as the block sees them.
  always @(posedge clk) begin
    if (!rst) begin
      if (rx_valid && rx_ready)
        sb.note_byte(rx_byte);
      if (out_valid && out_ready)
        sb.check_sample('{sample_value, sample_slot, last_of_run, status,
                          good_total, bad_total});
      if ((rx_valid && rx_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // Watchdog: too long with no transfer on either side means the block is stuck.
  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random back-pressure per phase; one long hold-off at the first
  // drain of the unthrottled phase, so the block fills and refuses input bytes.
  initial begin : sink
    int held;
    forever begin
      @(posedge clk);
      if (phase == PH_FREE && !hold_done && out_valid) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++)
          @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  task automatic set_phase(input traffic_phase_t ph);
    phase = ph;
    case (ph)
      PH_SRC_BUSY: begin
        src_idle_pct = 36;
        dst_idle_pct = 47;
      end
      PH_DST_BUSY: begin
        src_idle_pct = 47;
        dst_idle_pct = 36;
      end
      default: begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
    endcase
  endtask

  // Offers one byte, with a random gap first; returns on the edge of its transfer.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_byte  <= b;
    rx_valid <= 1'b1;
    @(posedge clk);
    while (!rx_ready)
      @(posedge clk);
    bytes_sent++;
  endtask

  // Sender pause until every owed sample has been transferred.
  task automatic wait_drained();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_q.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] noise_byte();
    logic [BYTE_W-1:0] b;
    do
      b = BYTE_W'($urandom);
    while (b == SYNC_BYTE);
    return b;
  endfunction

  // A few hunting bytes, then one full packet with random content.
  task automatic send_packet(input int idx, input bit intact);
    logic [BYTE_W-1:0] pkt [PKT_LEN];
    logic [BYTE_W-1:0] sum;
    int                k;
    int                gap;
    gap = $urandom_range(4);
    for (k = 0; k < gap; k++)
      send_byte(noise_byte());
    pkt[0] = SYNC_BYTE;
    for (k = 1; k < CHECK_POS; k++)
      pkt[k] = ($urandom_range(7) == 0) ? SYNC_BYTE : BYTE_W'($urandom);
    if (idx == 0) begin
      // first packet: sync as spare byte, all-zero and all-one values, sync pair as last value
      pkt[1]             = SYNC_BYTE;
      pkt[2]             = 8'h00;
      pkt[3]             = 8'h00;
      pkt[4]             = 8'hFF;
      pkt[5]             = 8'hFF;
      pkt[CHECK_POS - 2] = SYNC_BYTE;
      pkt[CHECK_POS - 1] = SYNC_BYTE;
    end
    sum = '0;
    for (k = 0; k < CHECK_POS; k++)
      sum = sum + pkt[k];
    pkt[CHECK_POS] = intact ? sum : sum + BYTE_W'($urandom_range(1, 255));
    for (k = 0; k < PKT_LEN; k++)
      send_byte(pkt[k]);
    packets_sent++;
  endtask

  initial begin : stimulus
    int pkt_idx;
    set_phase(PH_SRC_BUSY);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: hunting noise must give nothing
    foreach (HUNT_BYTES[k])
      send_byte(HUNT_BYTES[k]);

    // random packets: good, bad, good under hold-off, then either;
    // stop once another packet would overshoot the byte budget by more than half
    pkt_idx = 0;
    while (bytes_sent + PKT_LEN / 2 < ITEM_TARGET) begin
      if (pkt_idx == 1) begin
        wait_drained();
        set_phase(PH_DST_BUSY);
      end
      if (pkt_idx == 2) begin
        wait_drained();
        set_phase(PH_FREE);
      end
      send_packet(pkt_idx, (pkt_idx != 1) && (pkt_idx < 3 || $urandom_range(3) != 0));
      pkt_idx++;
    end
    repeat (3) send_byte(noise_byte());
    rx_valid <= 1'b0;

    @(posedge clk);
    while (sb.owed_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    // anything still owed here is a missing sample
    sb.mismatches += sb.owed_q.size();

    $display("Run: %0d bytes, %0d packets (%0d good, %0d checksum failures), %0d samples checked.",
             bytes_sent, packets_sent, sb.good_count, sb.bad_count, sb.samples_seen);
    $display("Traffic: each side throttled in turn, sender drain pauses, output hold-off %s.",
             hold_done ? "applied" : "not reached");
    if (sb.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
